// ===== hdl/rscc_pkg.sv =====
// Package for the region sum checksum checker.
// Holds register indexes, register reset values and field widths.
// No dependencies.
package rscc_pkg;

	localparam int REG_BITS  = 20;
	localparam int IDX_BITS  = 3;
	localparam int SUM_BITS  = 16;
	localparam int BYTE_BITS = 8;

	typedef logic [REG_BITS-1:0]  reg_word_t;
	typedef logic [IDX_BITS-1:0]  reg_idx_t;
	typedef logic [SUM_BITS-1:0]  sum_t;
	typedef logic [BYTE_BITS-1:0] byte_t;

	localparam reg_idx_t IDX_R1_START = 3'd0;
	localparam reg_idx_t IDX_R1_END   = 3'd1;
	localparam reg_idx_t IDX_R2_START = 3'd2;
	localparam reg_idx_t IDX_R2_END   = 3'd3;
	localparam reg_idx_t IDX_R3_START = 3'd4;
	localparam reg_idx_t IDX_R3_END   = 3'd5;
	localparam reg_idx_t IDX_MAIN_AT  = 3'd6;
	localparam reg_idx_t IDX_TAIL_AT  = 3'd7;

	localparam reg_word_t RST_R1_START = 20'h02000;
	localparam reg_word_t RST_R1_END   = 20'h03FFF;
	localparam reg_word_t RST_R2_START = 20'h10000;
	localparam reg_word_t RST_R2_END   = 20'h6FFFD;
	localparam reg_word_t RST_R3_START = 20'h72806;
	localparam reg_word_t RST_R3_END   = 20'h7FFFF;
	localparam reg_word_t RST_MAIN_AT  = 20'h6FFFE;
	localparam reg_word_t RST_TAIL_AT  = 20'h72804;

endpackage

// ===== hdl/region_sum_checksum_checker.sv =====
// Region sum checksum checker: top level, single pass per input word.
// A last word passes through the input register and then the result register before it reaches the output.
// Throughput: one word per cycle while the input is not stalled; the input register feeds one add/compare pass.
// Input stalls only while a last word waits behind a stalled result.
// Reset clears sums, captured words, valids and config registers to defaults.
// Depends on rscc_pkg.
module region_sum_checksum_checker #(
	parameter int ADDR_BITS = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  rscc_pkg::reg_idx_t          cfg_index,
	input  rscc_pkg::reg_word_t         cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rscc_pkg::REG_BITS-1:0] byte_addr,
	input  rscc_pkg::byte_t             byte_value,
	input  logic                        last_byte,
	input  logic                        repair,
	output logic                        out_valid,
	input  logic                        out_stall,
	output rscc_pkg::sum_t              main_sum,
	output rscc_pkg::sum_t              tail_sum,
	output rscc_pkg::sum_t              stored_main,
	output rscc_pkg::sum_t              stored_tail,
	output logic                        main_bad,
	output logic                        tail_bad,
	output logic [1:0]                  bad_count,
	output logic                        patch_main,
	output logic                        patch_tail
);

	localparam int CW = (ADDR_BITS < rscc_pkg::REG_BITS) ? ADDR_BITS : rscc_pkg::REG_BITS;
	localparam int HW = (ADDR_BITS > CW) ? CW + 1 : CW;

	rscc_pkg::reg_word_t r1_start_q, r1_end_q, r2_start_q, r2_end_q;
	rscc_pkg::reg_word_t r3_start_q, r3_end_q, main_at_q, tail_at_q;

	logic                 valid_s1;
	logic [CW-1:0]        addr_s1;
	rscc_pkg::byte_t      value_s1;
	logic                 last_s1;
	logic                 repair_s1;

	rscc_pkg::sum_t main_acc_q, tail_acc_q, main_st_q, tail_st_q;

	logic           s1_adv;
	logic           in1, in2, in3;
	rscc_pkg::sum_t vext;
	rscc_pkg::sum_t main_nx, tail_nx, main_st_nx, tail_st_nx;
	logic [HW-1:0]  addr_h;
	logic [HW-1:0]  main_hi, tail_hi;
	logic           mbad_nx, tbad_nx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r1_start_q <= rscc_pkg::RST_R1_START;
			r1_end_q   <= rscc_pkg::RST_R1_END;
			r2_start_q <= rscc_pkg::RST_R2_START;
			r2_end_q   <= rscc_pkg::RST_R2_END;
			r3_start_q <= rscc_pkg::RST_R3_START;
			r3_end_q   <= rscc_pkg::RST_R3_END;
			main_at_q  <= rscc_pkg::RST_MAIN_AT;
			tail_at_q  <= rscc_pkg::RST_TAIL_AT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rscc_pkg::IDX_R1_START: r1_start_q <= cfg_data;
				rscc_pkg::IDX_R1_END:   r1_end_q   <= cfg_data;
				rscc_pkg::IDX_R2_START: r2_start_q <= cfg_data;
				rscc_pkg::IDX_R2_END:   r2_end_q   <= cfg_data;
				rscc_pkg::IDX_R3_START: r3_start_q <= cfg_data;
				rscc_pkg::IDX_R3_END:   r3_end_q   <= cfg_data;
				rscc_pkg::IDX_MAIN_AT:  main_at_q  <= cfg_data;
				rscc_pkg::IDX_TAIL_AT:  tail_at_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold a last word while the result register is full and stalled
	assign s1_adv   = valid_s1 && (!last_s1 || !out_valid || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			addr_s1   <= byte_addr[CW-1:0];
			value_s1  <= byte_value;
			last_s1   <= last_byte;
			repair_s1 <= repair;
		end
	end

	always_comb begin
		in1  = (addr_s1 >= r1_start_q[CW-1:0]) && (addr_s1 <= r1_end_q[CW-1:0]);
		in2  = (addr_s1 >= r2_start_q[CW-1:0]) && (addr_s1 <= r2_end_q[CW-1:0]);
		in3  = (addr_s1 >= r3_start_q[CW-1:0]) && (addr_s1 <= r3_end_q[CW-1:0]);
		vext = {{(rscc_pkg::SUM_BITS-rscc_pkg::BYTE_BITS){1'b0}}, value_s1};
		main_nx = main_acc_q + (in1 ? vext : '0) + (in2 ? vext : '0);
		tail_nx = tail_acc_q + (in3 ? vext : '0);

		addr_h  = HW'(addr_s1);
		main_hi = HW'(main_at_q[CW-1:0]) + HW'(1);
		tail_hi = HW'(tail_at_q[CW-1:0]) + HW'(1);

		main_st_nx = main_st_q;
		if (addr_s1 == main_at_q[CW-1:0]) main_st_nx[7:0] = value_s1;
		if (addr_h == main_hi) main_st_nx[15:8] = value_s1;
		tail_st_nx = tail_st_q;
		if (addr_s1 == tail_at_q[CW-1:0]) tail_st_nx[7:0] = value_s1;
		if (addr_h == tail_hi) tail_st_nx[15:8] = value_s1;

		mbad_nx = main_st_nx != main_nx;
		tbad_nx = tail_st_nx != tail_nx;
	end

	// clear running state after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_acc_q <= '0;
			tail_acc_q <= '0;
			main_st_q  <= '0;
			tail_st_q  <= '0;
		end else if (s1_adv) begin
			if (last_s1) begin
				main_acc_q <= '0;
				tail_acc_q <= '0;
				main_st_q  <= '0;
				tail_st_q  <= '0;
			end else begin
				main_acc_q <= main_nx;
				tail_acc_q <= tail_nx;
				main_st_q  <= main_st_nx;
				tail_st_q  <= tail_st_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			main_sum    <= main_nx;
			tail_sum    <= tail_nx;
			stored_main <= main_st_nx;
			stored_tail <= tail_st_nx;
			main_bad    <= mbad_nx;
			tail_bad    <= tbad_nx;
			bad_count   <= {1'b0, mbad_nx} + {1'b0, tbad_nx};
			patch_main  <= repair_s1 && mbad_nx;
			patch_tail  <= repair_s1 && tbad_nx;
		end
	end

	a_bad_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bad_count == ({1'b0, main_bad} + {1'b0, tail_bad}))
		else $error("bad_count disagrees with mismatch flags");

	a_patch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (patch_main || patch_tail) |->
		(!patch_main || main_bad) && (!patch_tail || tail_bad))
		else $error("patch flag without mismatch");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> main_acc_q == '0 && tail_acc_q == '0 &&
		main_st_q == '0 && tail_st_q == '0)
		else $error("state not cleared after last word");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked result");

	a_result_set: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> out_valid)
		else $error("last word did not raise a result");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for region_sum_checksum_checker: streams image bytes, predicts each
// end-of-image checksum report in a scoreboard class and checks the DUT against it.
// Depends on rscc_pkg and the checker RTL.

typedef struct packed {
	rscc_pkg::sum_t main_sum;
	rscc_pkg::sum_t tail_sum;
	rscc_pkg::sum_t stored_main;
	rscc_pkg::sum_t stored_tail;
	logic           main_bad;
	logic           tail_bad;
	logic [1:0]     bad_count;
	logic           patch_main;
	logic           patch_tail;
} sum_report_t;

class checksum_scoreboard #(int ADDR_BITS = 20);
	localparam rscc_pkg::reg_word_t ADDR_MASK = rscc_pkg::reg_word_t'((64'd1 << ADDR_BITS) - 1);

	rscc_pkg::reg_word_t regs [1 << rscc_pkg::IDX_BITS];
	rscc_pkg::sum_t      main_acc;
	rscc_pkg::sum_t      tail_acc;
	rscc_pkg::sum_t      main_word;
	rscc_pkg::sum_t      tail_word;
	sum_report_t         reports_due [$];
	int                  mismatches;
	int                  reports_seen;

	function new();
		regs[rscc_pkg::IDX_R1_START] = rscc_pkg::RST_R1_START;
		regs[rscc_pkg::IDX_R1_END]   = rscc_pkg::RST_R1_END;
		regs[rscc_pkg::IDX_R2_START] = rscc_pkg::RST_R2_START;
		regs[rscc_pkg::IDX_R2_END]   = rscc_pkg::RST_R2_END;
		regs[rscc_pkg::IDX_R3_START] = rscc_pkg::RST_R3_START;
		regs[rscc_pkg::IDX_R3_END]   = rscc_pkg::RST_R3_END;
		regs[rscc_pkg::IDX_MAIN_AT]  = rscc_pkg::RST_MAIN_AT;
		regs[rscc_pkg::IDX_TAIL_AT]  = rscc_pkg::RST_TAIL_AT;
		mismatches = 0;
		reports_seen = 0;
		clear_image();
	endfunction

	function void clear_image();
		main_acc = '0;
		tail_acc = '0;
		main_word = '0;
		tail_word = '0;
	endfunction

	function void write_reg(rscc_pkg::reg_idx_t idx, rscc_pkg::reg_word_t data);
		regs[idx] = data;
	endfunction

	function bit hits(rscc_pkg::reg_word_t a, rscc_pkg::reg_idx_t lo, rscc_pkg::reg_idx_t hi);
		return a >= (regs[lo] & ADDR_MASK) && a <= (regs[hi] & ADDR_MASK);
	endfunction

	function rscc_pkg::sum_t grab(rscc_pkg::sum_t word, rscc_pkg::reg_word_t a,
			rscc_pkg::reg_word_t where, rscc_pkg::byte_t v);
		rscc_pkg::reg_word_t lo;
		rscc_pkg::reg_word_t hi;
		lo = where & ADDR_MASK;
		hi = rscc_pkg::reg_word_t'(lo + 1) & ADDR_MASK;
		if (a == lo)
			word[7:0] = v;
		if (a == hi)
			word[15:8] = v;
		return word;
	endfunction

	function void note_byte(rscc_pkg::reg_word_t addr, rscc_pkg::byte_t v, logic last,
			logic rep);
		rscc_pkg::reg_word_t a;
		sum_report_t         r;
		a = addr & ADDR_MASK;
		if (hits(a, rscc_pkg::IDX_R1_START, rscc_pkg::IDX_R1_END))
			main_acc += v;
		if (hits(a, rscc_pkg::IDX_R2_START, rscc_pkg::IDX_R2_END))
			main_acc += v;
		if (hits(a, rscc_pkg::IDX_R3_START, rscc_pkg::IDX_R3_END))
			tail_acc += v;
		main_word = grab(main_word, a, regs[rscc_pkg::IDX_MAIN_AT], v);
		tail_word = grab(tail_word, a, regs[rscc_pkg::IDX_TAIL_AT], v);
		if (last) begin
			r.main_sum = main_acc;
			r.tail_sum = tail_acc;
			r.stored_main = main_word;
			r.stored_tail = tail_word;
			r.main_bad = main_word != main_acc;
			r.tail_bad = tail_word != tail_acc;
			r.bad_count = 2'(r.main_bad) + 2'(r.tail_bad);
			r.patch_main = rep && r.main_bad;
			r.patch_tail = rep && r.tail_bad;
			reports_due.push_back(r);
			clear_image();
		end
	endfunction

	function void flag(string what, sum_report_t want, sum_report_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: main %h/%h tail %h/%h stored %h/%h %h/%h bad %b%b/%b%b cnt %0d/%0d patch %b%b/%b%b (exp/act)",
				$realtime, what, want.main_sum, got.main_sum, want.tail_sum, got.tail_sum,
				want.stored_main, got.stored_main, want.stored_tail, got.stored_tail,
				want.main_bad, want.tail_bad, got.main_bad, got.tail_bad,
				want.bad_count, got.bad_count,
				want.patch_main, want.patch_tail, got.patch_main, got.patch_tail);
	endfunction

	function void check_report(sum_report_t got);
		sum_report_t want;
		reports_seen++;
		if (reports_due.size() == 0) begin
			flag("report with none expected", '0, got);
		end else begin
			want = reports_due.pop_front();
			if (got !== want)
				flag("report mismatch", want, got);
		end
	endfunction
endclass

module tb;
	localparam int                  ADDR_BITS = 20;
	localparam rscc_pkg::reg_word_t TOP_ADDR  = '1;
	localparam int                  WIN_SPAN  = 511;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	rscc_pkg::reg_idx_t  cfg_index = rscc_pkg::IDX_R1_START;
	rscc_pkg::reg_word_t cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	rscc_pkg::reg_word_t byte_addr = '0;
	rscc_pkg::byte_t     byte_value = '0;
	logic                last_byte = 1'b0;
	logic                repair = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	rscc_pkg::sum_t      main_sum;
	rscc_pkg::sum_t      tail_sum;
	rscc_pkg::sum_t      stored_main;
	rscc_pkg::sum_t      stored_tail;
	logic                main_bad;
	logic                tail_bad;
	logic [1:0]          bad_count;
	logic                patch_main;
	logic                patch_tail;

	checksum_scoreboard #(ADDR_BITS) sb;
	int                  idle_pct = 0;
	int                  stall_pct = 0;
	int                  bytes_sent = 0;
	int                  settings_used = 1;
	int                  images;
	int                  target;
	rscc_pkg::reg_word_t win_base = '0;
	rscc_pkg::reg_word_t setting [1 << rscc_pkg::IDX_BITS];

	region_sum_checksum_checker #(.ADDR_BITS(ADDR_BITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .byte_addr(byte_addr),
		.byte_value(byte_value), .last_byte(last_byte), .repair(repair),
		.out_valid(out_valid), .out_stall(out_stall),
		.main_sum(main_sum), .tail_sum(tail_sum), .stored_main(stored_main),
		.stored_tail(stored_tail), .main_bad(main_bad), .tail_bad(tail_bad),
		.bad_count(bad_count), .patch_main(patch_main), .patch_tail(patch_tail)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_byte(byte_addr, byte_value, last_byte, repair);
			if (out_valid && !out_stall)
				sb.check_report({main_sum, tail_sum, stored_main, stored_tail, main_bad,
					tail_bad, bad_count, patch_main, patch_tail});
		end
	end

	task automatic cfg_write(rscc_pkg::reg_idx_t idx, rscc_pkg::reg_word_t data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic apply_setting();
		for (int i = 0; i < $size(setting); i++)
			cfg_write(rscc_pkg::reg_idx_t'(i), setting[i]);
		cfg_valid = 1'b0;
		settings_used++;
	endtask

	task automatic send_byte(rscc_pkg::reg_word_t a, rscc_pkg::byte_t v, logic last, logic rep);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		byte_addr = a;
		byte_value = v;
		last_byte = last;
		repair = rep;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		bytes_sent++;
	endtask

	// drain all reports and let the pipeline empty before touching registers
	task automatic settle();
		in_valid = 1'b0;
		while (sb.reports_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic pick_region(output rscc_pkg::reg_word_t s, output rscc_pkg::reg_word_t e);
		int lo;
		int hi;
		int tmp;
		bit want_empty;
		lo = $urandom_range(WIN_SPAN);
		hi = $urandom_range(WIN_SPAN);
		want_empty = ($urandom_range(7) == 0);
		if ((lo > hi) != want_empty) begin
			tmp = lo;
			lo = hi;
			hi = tmp;
		end
		s = rscc_pkg::reg_word_t'(win_base + lo);
		e = rscc_pkg::reg_word_t'(win_base + hi);
	endtask

	task automatic random_setting();
		case ($urandom_range(5))
			0: win_base = '0;
			1: win_base = rscc_pkg::reg_word_t'(TOP_ADDR - WIN_SPAN);
			default: win_base = rscc_pkg::reg_word_t'($urandom_range(TOP_ADDR - WIN_SPAN));
		endcase
		pick_region(setting[rscc_pkg::IDX_R1_START], setting[rscc_pkg::IDX_R1_END]);
		pick_region(setting[rscc_pkg::IDX_R2_START], setting[rscc_pkg::IDX_R2_END]);
		pick_region(setting[rscc_pkg::IDX_R3_START], setting[rscc_pkg::IDX_R3_END]);
		if ($urandom_range(9) == 0) begin
			setting[rscc_pkg::IDX_R1_START] = '0;
			setting[rscc_pkg::IDX_R1_END] = TOP_ADDR;
		end
		setting[rscc_pkg::IDX_MAIN_AT] =
			rscc_pkg::reg_word_t'(win_base + $urandom_range(WIN_SPAN));
		setting[rscc_pkg::IDX_TAIL_AT] =
			rscc_pkg::reg_word_t'(win_base + $urandom_range(WIN_SPAN));
		if (win_base == rscc_pkg::reg_word_t'(TOP_ADDR - WIN_SPAN) && $urandom_range(1)) begin
			if ($urandom_range(1))
				setting[rscc_pkg::IDX_TAIL_AT] = TOP_ADDR;
			else
				setting[rscc_pkg::IDX_MAIN_AT] = TOP_ADDR;
		end
	endtask

	// one image; up to about a quarter end with correct stored checksums, as many with one byte off
	task automatic run_image();
		int                  len;
		int                  flip;
		bit                  good;
		rscc_pkg::reg_word_t a;
		rscc_pkg::byte_t     v;
		rscc_pkg::sum_t      word;
		rscc_pkg::reg_word_t spots [4];
		spots[0] = setting[rscc_pkg::IDX_MAIN_AT];
		spots[1] = rscc_pkg::reg_word_t'(setting[rscc_pkg::IDX_MAIN_AT] + 1);
		spots[2] = setting[rscc_pkg::IDX_TAIL_AT];
		spots[3] = rscc_pkg::reg_word_t'(setting[rscc_pkg::IDX_TAIL_AT] + 1);
		good = ($urandom_range(9) < 5);
		for (int i = 0; i < 4; i++) begin
			if (sb.hits(spots[i], rscc_pkg::IDX_R1_START, rscc_pkg::IDX_R1_END) ||
					sb.hits(spots[i], rscc_pkg::IDX_R2_START, rscc_pkg::IDX_R2_END))
				good = 1'b0;
			if (i >= 2 && sb.hits(spots[i], rscc_pkg::IDX_R3_START, rscc_pkg::IDX_R3_END))
				good = 1'b0;
			for (int j = 0; j < i; j++)
				if (spots[i] == spots[j])
					good = 1'b0;
		end
		len = ($urandom_range(7) == 0) ? 1 : $urandom_range(40, 2);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(19))
				0: a = rscc_pkg::reg_word_t'($urandom);
				1: a = spots[$urandom_range(3)];
				default: a = rscc_pkg::reg_word_t'(win_base + $urandom_range(WIN_SPAN));
			endcase
			send_byte(a, rscc_pkg::byte_t'($urandom_range(255)), !good && i == len - 1,
				1'($urandom_range(1)));
		end
		if (good) begin
			flip = $urandom_range(7);
			for (int i = 0; i < 4; i++) begin
				word = (i < 2) ? sb.main_acc : sb.tail_acc;
				v = i[0] ? word[15:8] : word[7:0];
				if (flip == i)
					v = v ^ rscc_pkg::byte_t'($urandom_range(255, 1));
				send_byte(spots[i], v, i == 3, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		sb = new();
		idle_pct = 10;
		stall_pct = 86;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_byte(20'h00000, 8'h00, 1'b0, 1'b0);
		send_byte(20'h02000, 8'hFF, 1'b0, 1'b1);
		send_byte(20'h03FFF, 8'h80, 1'b0, 1'b0);
		send_byte(20'h10000, 8'h01, 1'b0, 1'b0);
		send_byte(20'h6FFFD, 8'h7F, 1'b0, 1'b0);
		send_byte(20'h6FFFE, 8'h34, 1'b0, 1'b0);
		send_byte(20'h6FFFF, 8'h12, 1'b0, 1'b0);
		send_byte(20'h72804, 8'hCD, 1'b0, 1'b0);
		send_byte(20'h72805, 8'hAB, 1'b0, 1'b0);
		send_byte(20'h72806, 8'h55, 1'b0, 1'b0);
		send_byte(20'hFFFFF, 8'hAA, 1'b1, 1'b1);
		send_byte(20'h00001, 8'h00, 1'b1, 1'b1);
		send_byte(20'h7FFFF, 8'hFF, 1'b1, 1'b0);
		settle();

		// full-range region one overlapping region two, empty tail region,
		// tail checksum at the top address so its high byte wraps to zero
		setting[rscc_pkg::IDX_R1_START] = '0;
		setting[rscc_pkg::IDX_R1_END]   = TOP_ADDR;
		setting[rscc_pkg::IDX_R2_START] = 20'h00100;
		setting[rscc_pkg::IDX_R2_END]   = 20'h001FF;
		setting[rscc_pkg::IDX_R3_START] = 20'h00200;
		setting[rscc_pkg::IDX_R3_END]   = 20'h00100;
		setting[rscc_pkg::IDX_MAIN_AT]  = 20'h00150;
		setting[rscc_pkg::IDX_TAIL_AT]  = TOP_ADDR;
		apply_setting();
		send_byte(20'h00150, 8'h10, 1'b0, 1'b0);
		send_byte(20'h00150, 8'h20, 1'b0, 1'b0);
		send_byte(20'hFFFFF, 8'h00, 1'b0, 1'b0);
		send_byte(20'h00000, 8'h00, 1'b1, 1'b1);
		send_byte(20'hFFFFF, 8'hC3, 1'b0, 1'b1);
		send_byte(20'h00000, 8'h5A, 1'b1, 1'b0);
		settle();

		for (int p = 0; p < 3; p++) begin
			idle_pct = (p == 0) ? 10 : (p == 1) ? 86 : 0;
			stall_pct = (p == 0) ? 86 : (p == 1) ? 10 : 0;
			if (p == 0) begin
				random_setting();
			end else begin
				win_base = (p == 1) ? '0 : rscc_pkg::reg_word_t'(TOP_ADDR - WIN_SPAN);
				for (int i = 0; i < $size(setting); i++)
					setting[i] = (p == 1) ? '0 : TOP_ADDR;
			end
			apply_setting();
			target = bytes_sent + 350;
			images = 0;
			while (bytes_sent < target) begin
				run_image();
				images++;
				if (images % 3 == 0) begin
					settle();
					random_setting();
					apply_setting();
				end
			end
			settle();
		end
		repeat (8) @(posedge clk);

		$display("Checked %0d checksum reports over %0d image bytes and %0d register settings,",
			sb.reports_seen, bytes_sent, settings_used);
		$display("with overlapping, empty and full-range regions and wrapped checksum addresses.");
		if (sb.mismatches == 0 && sb.reports_due.size() == 0) begin
			$display("** region_sum_checksum_checker: PASSED **");
		end else begin
			$display("%0d bad reports, %0d reports missing", sb.mismatches,
				sb.reports_due.size());
			$display("** region_sum_checksum_checker: FAILED **");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d reports outstanding", sb.reports_due.size());
		$display("** region_sum_checksum_checker: FAILED **");
		$finish;
	end
endmodule
